/* rtl/assert_macros.svh */
// assert_macros.svh: assertion macros shared by the filter RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* rtl/inmr_pkg.sv */
// inmr_pkg.sv: types, constants and helper functions of the impulse noise filter.
// Depends on nothing; used by inmr_filter, inmr_out_fifo and the core.
package inmr_pkg;

	localparam int unsigned MAX_WIDTH  = 2048;
	localparam int unsigned MAX_HEIGHT = 2048;

	localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
	localparam int unsigned WDIM_W = $clog2(MAX_WIDTH + 1);
	localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT);
	localparam int unsigned HDIM_W = $clog2(MAX_HEIGHT + 1);

	localparam int unsigned CFG_DIM_W   = 12;
	localparam int unsigned STRENGTH_W  = 5;
	localparam int unsigned CFG_DATA_W  = 12;
	localparam int unsigned CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_STRENGTH = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_WIDTH    = CFG_INDEX_W'(1);
	localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT   = CFG_INDEX_W'(2);

	localparam int unsigned WIDTH_RESET  = 640;
	localparam int unsigned HEIGHT_RESET = 480;

	localparam int unsigned STRENGTH_MAX = 20;
	localparam int unsigned TOL_BASE     = 100;
	localparam int unsigned TOL_STEP     = 5;
	localparam int unsigned TOL_W        = 7;
	localparam int unsigned CH_MAX       = 255;

	localparam int unsigned NEIGH_SUM_W = 11;
	localparam int unsigned AVG_SHIFT   = 3;

	localparam int unsigned PEND_W = 12;
	localparam logic [PEND_W-1:0] PEND_MAX = '1;

	localparam int unsigned OUT_FIFO_DEPTH = 8;
	localparam int unsigned FIFO_PTR_W     = $clog2(OUT_FIFO_DEPTH);
	localparam int unsigned FIFO_CNT_W     = $clog2(OUT_FIFO_DEPTH + 1);

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	// Middle line store entry: live is low for entries written by a flush beat.
	typedef struct packed {
		logic   live;
		pixel_t pix;
	} mid_entry_t;

	typedef struct packed {
		pixel_t pix;
		logic   last;
	} result_t;

	// Control that travels with a window into the filter datapath.
	typedef struct packed {
		logic valid;
		logic border;
		logic last;
	} win_ctl_t;

	function automatic logic [WDIM_W-1:0] eff_width(input logic [CFG_DIM_W-1:0] v);
		if (v == '0) begin
			return WDIM_W'(1);
		end else if (32'(v) > MAX_WIDTH) begin
			return WDIM_W'(MAX_WIDTH);
		end
		return WDIM_W'(v);
	endfunction

	function automatic logic [HDIM_W-1:0] eff_height(input logic [CFG_DIM_W-1:0] v);
		if (v == '0) begin
			return HDIM_W'(1);
		end else if (32'(v) > MAX_HEIGHT) begin
			return HDIM_W'(MAX_HEIGHT);
		end
		return HDIM_W'(v);
	endfunction

	function automatic logic [TOL_W-1:0] tolerance(input logic [STRENGTH_W-1:0] strength);
		logic [STRENGTH_W-1:0] s;
		s = (strength > STRENGTH_W'(STRENGTH_MAX)) ? STRENGTH_W'(STRENGTH_MAX) : strength;
		return TOL_W'(TOL_BASE - TOL_STEP * 32'(s));
	endfunction

endpackage

/* rtl/inmr_in_if.sv */
// inmr_in_if.sv: pixel channel into the filter, valid/ready with RGB and flush flag.
// Depends on nothing.
interface inmr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;
	logic       is_padding;

	modport source (output valid, in_red, in_green, in_blue, is_padding, input ready);
	modport sink (input valid, in_red, in_green, in_blue, is_padding, output ready);
endinterface

/* rtl/inmr_out_if.sv */
// inmr_out_if.sv: filtered pixel channel out of the filter, valid/ready with RGB.
// Depends on nothing.
interface inmr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic       last_of_frame;

	modport source (output valid, out_red, out_green, out_blue, last_of_frame, input ready);
	modport sink (input valid, out_red, out_green, out_blue, last_of_frame, output ready);
endinterface

/* rtl/inmr_filter.sv */
// inmr_filter.sv: neighbor mean, registered, then outlier replacement.
// Depends on inmr_pkg.
module inmr_filter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  inmr_pkg::pixel_t                   window [9],
	input  inmr_pkg::win_ctl_t                 ctl,
	input  logic [inmr_pkg::STRENGTH_W-1:0]    strength,
	output logic                               push,
	output inmr_pkg::result_t                  result
);

	inmr_pkg::win_ctl_t ctl_s3;
	inmr_pkg::pixel_t   avg_s3;
	inmr_pkg::pixel_t   centre_s3;

	logic [inmr_pkg::NEIGH_SUM_W-1:0] sum [3];
	logic [23:0]                      avg_d;
	logic [inmr_pkg::TOL_W-1:0]       tol;
	logic                             outlier;

	// Sum of the eight neighbors in each channel; the centre is skipped.
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			sum[ch] = '0;
			for (int i = 0; i < 9; i++) begin
				if (i != 4) begin
					sum[ch] = sum[ch] + inmr_pkg::NEIGH_SUM_W'(window[i][8*ch +: 8]);
				end
			end
			avg_d[8*ch +: 8] = sum[ch][inmr_pkg::AVG_SHIFT +: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else begin
			ctl_s3 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		avg_s3    <= avg_d;
		centre_s3 <= window[4];
	end

	assign tol = inmr_pkg::tolerance(strength);

	// Band check: centre outside [max(avg-tol,0), min(avg+tol,255)] in any channel.
	always_comb begin
		logic [7:0] a;
		logic [7:0] c;
		logic [7:0] lo;
		logic [8:0] hi;
		outlier = 1'b0;
		for (int ch = 0; ch < 3; ch++) begin
			a  = avg_s3[8*ch +: 8];
			c  = centre_s3[8*ch +: 8];
			lo = (a > 8'(tol)) ? a - 8'(tol) : 8'd0;
			hi = {1'b0, a} + 9'(tol);
			if (hi > 9'(inmr_pkg::CH_MAX)) begin
				hi = 9'(inmr_pkg::CH_MAX);
			end
			if ((c < lo) || ({1'b0, c} > hi)) begin
				outlier = 1'b1;
			end
		end
	end

	assign push        = ctl_s3.valid;
	assign result.pix  = (!ctl_s3.border && outlier) ? avg_s3 : centre_s3;
	assign result.last = ctl_s3.last;

endmodule

/* rtl/inmr_out_fifo.sv */
// inmr_out_fifo.sv: small result queue that drives the output channel.
// Depends on inmr_pkg, inmr_out_if and assert_macros.svh.
`include "assert_macros.svh"

module inmr_out_fifo (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  inmr_pkg::result_t                 push_data,
	inmr_out_if.source                        results,
	output logic [inmr_pkg::FIFO_CNT_W-1:0]   count
);

	inmr_pkg::result_t                     mem_q [inmr_pkg::OUT_FIFO_DEPTH];
	logic [inmr_pkg::FIFO_PTR_W-1:0]       wr_ptr_q;
	logic [inmr_pkg::FIFO_PTR_W-1:0]       rd_ptr_q;
	logic [inmr_pkg::FIFO_CNT_W-1:0]       count_q;
	logic                                  pop;
	inmr_pkg::result_t                     head;

	function automatic logic [inmr_pkg::FIFO_PTR_W-1:0] next_ptr(
		input logic [inmr_pkg::FIFO_PTR_W-1:0] p
	);
		if (p == inmr_pkg::FIFO_PTR_W'(inmr_pkg::OUT_FIFO_DEPTH - 1)) begin
			return '0;
		end
		return p + inmr_pkg::FIFO_PTR_W'(1);
	endfunction

	assign pop  = results.valid && results.ready;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + inmr_pkg::FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - inmr_pkg::FIFO_CNT_W'(1);
			end
		end
	end

	assign results.valid         = (count_q != '0);
	assign results.out_red       = head.pix.red;
	assign results.out_green     = head.pix.green;
	assign results.out_blue      = head.pix.blue;
	assign results.last_of_frame = head.last;
	assign count                 = count_q;

	`ASSERT_IMPLIES(push_not_full, clk, arst_n, push && !pop, count_q < inmr_pkg::FIFO_CNT_W'(inmr_pkg::OUT_FIFO_DEPTH), "result pushed into a full queue")
	`ASSERT_NEXT(count_up, clk, arst_n, push && !pop, count_q == $past(count_q) + inmr_pkg::FIFO_CNT_W'(1), "queue count did not rise on push")
	`ASSERT_NEXT(count_down, clk, arst_n, pop && !push, count_q == $past(count_q) - inmr_pkg::FIFO_CNT_W'(1), "queue count did not fall on pop")

endmodule

/* rtl/impulse_noise_mean_replace_3x3_core.sv */
// impulse_noise_mean_replace_3x3_core.sv: top level of the 3x3 impulse noise filter.
// Depends on inmr_pkg, inmr_in_if, inmr_out_if, inmr_filter, inmr_out_fifo, assert_macros.svh.
//
//   channel          | direction | payload                                  | handshake
//   -----------------+-----------+------------------------------------------+-----------
//   pixel_stream     | sink      | in_red, in_green, in_blue, is_padding    | valid/ready
//   filtered_stream  | source    | out_red, out_green, out_blue, last_of_frame | valid/ready
//   cfg_*            | sink      | cfg_index, cfg_data                      | cfg_we only
//
// One beat is taken per clock while pixel_stream.ready is high. A beat reads the two line
// stores (one synchronous read port each), then shifts the window and writes the stores
// back, then the neighbor means are formed, then the band check is made; a pixel's result
// enters the output queue from the stage 3 registers, after the beat that makes it the
// window centre, which is the beat image_width+1 positions after its own.
// Reset clears all control state at once; there is no clearing pass, because a fill
// count marks which middle line store entries have ever been written.
// pixel_stream.ready depends on registers only: it drops when the output queue plus
// the beats still in the pipeline would reach the queue depth, so a stalled output
// stops intake after a few beats and never loses a result.

`include "assert_macros.svh"

module impulse_noise_mean_replace_3x3_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [inmr_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [inmr_pkg::CFG_DATA_W-1:0]      cfg_data,
	inmr_in_if.sink                              pixel_stream,
	inmr_out_if.source                           filtered_stream
);

	localparam int unsigned COL_W  = inmr_pkg::COL_W;
	localparam int unsigned WDIM_W = inmr_pkg::WDIM_W;
	localparam int unsigned ROW_W  = inmr_pkg::ROW_W;
	localparam int unsigned HDIM_W = inmr_pkg::HDIM_W;
	localparam int unsigned PEND_W = inmr_pkg::PEND_W;
	localparam int unsigned CNT_W  = inmr_pkg::FIFO_CNT_W;

	// Configuration registers.
	logic [inmr_pkg::STRENGTH_W-1:0] strength_q;
	logic [inmr_pkg::CFG_DIM_W-1:0]  image_width_q;
	logic [inmr_pkg::CFG_DIM_W-1:0]  image_height_q;

	logic [WDIM_W-1:0] w_eff;
	logic [HDIM_W-1:0] h_eff;

	// Input side frame position and line store pointer.
	logic [COL_W-1:0]  store_ptr_q;
	logic [WDIM_W-1:0] fill_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [PEND_W-1:0] pending_q;

	// Output side frame position.
	logic [COL_W-1:0] out_col_q;
	logic [ROW_W-1:0] out_row_q;

	// Line stores: the row above the middle row, and the middle row with its live flag.
	inmr_pkg::pixel_t     upper_mem  [inmr_pkg::MAX_WIDTH];
	inmr_pkg::mid_entry_t middle_mem [inmr_pkg::MAX_WIDTH];

	// Window: three columns of three pixels, column 2 is the newest.
	inmr_pkg::pixel_t window_q [9];
	logic [2:0]       win_live_q;

	// Stage 0 (intake) signals.
	inmr_pkg::pixel_t  pix_in;
	logic              accept;
	logic              pad;
	logic              pad_taken;
	logic              shift_s0;
	logic [COL_W-1:0]  k_s0;
	logic [WDIM_W-1:0] k_ext;
	logic              store_wrap;
	logic              col_wrap;
	logic              row_wrap;
	logic [PEND_W-1:0] pending_cur;

	// Stage 1 registers: read data and the beat that issued the read.
	logic                 v_s1;
	logic [COL_W-1:0]     k_s1;
	inmr_pkg::pixel_t     pix_s1;
	logic                 pad_s1;
	logic                 written_s1;
	logic                 byp_s1;
	inmr_pkg::pixel_t     byp_up_s1;
	inmr_pkg::mid_entry_t byp_mid_s1;
	inmr_pkg::pixel_t     up_rd_s1;
	inmr_pkg::mid_entry_t mid_rd_s1;

	// Stage 1 signals.
	inmr_pkg::pixel_t  up_cur;
	inmr_pkg::pixel_t  mid_cur;
	logic              mid_live;
	logic              emit;
	logic              ocol_last;
	logic              orow_last;
	logic              border;
	logic              last;
	logic [PEND_W-1:0] pend_inc;
	logic [PEND_W-1:0] pend_upd;

	// Stage 2 control, stage 3 push into the queue.
	inmr_pkg::win_ctl_t ctl_s2;
	logic               push;
	inmr_pkg::result_t  result;
	logic [CNT_W-1:0]   fifo_count;
	logic [CNT_W:0]     used;

	// ---------------------------------------------------------------- configuration

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strength_q     <= '0;
			image_width_q  <= inmr_pkg::CFG_DIM_W'(inmr_pkg::WIDTH_RESET);
			image_height_q <= inmr_pkg::CFG_DIM_W'(inmr_pkg::HEIGHT_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				inmr_pkg::REG_STRENGTH: begin
					strength_q <= cfg_data[inmr_pkg::STRENGTH_W-1:0];
				end
				inmr_pkg::REG_WIDTH: begin
					image_width_q <= cfg_data[inmr_pkg::CFG_DIM_W-1:0];
				end
				inmr_pkg::REG_HEIGHT: begin
					image_height_q <= cfg_data[inmr_pkg::CFG_DIM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign w_eff = inmr_pkg::eff_width(image_width_q);
	assign h_eff = inmr_pkg::eff_height(image_height_q);

	// ---------------------------------------------------------------- stage 0: intake

	assign used = {1'b0, fifo_count} + (CNT_W+1)'(v_s1) + (CNT_W+1)'(ctl_s2.valid)
		+ (CNT_W+1)'(push);
	assign pixel_stream.ready = (used < (CNT_W+1)'(inmr_pkg::OUT_FIFO_DEPTH));

	assign accept = pixel_stream.valid && pixel_stream.ready;
	assign pad    = pixel_stream.is_padding;
	assign pix_in = '{red: pixel_stream.in_red, green: pixel_stream.in_green,
		blue: pixel_stream.in_blue};

	// The beat in stage 1 settles its pending count this cycle; the intake sees that value.
	assign pending_cur = v_s1 ? pend_upd : pending_q;

	// A flush beat only counts at the start of a frame while results are still owed.
	assign pad_taken = (pending_cur != '0) && (col_q == '0) && (row_q == '0);
	assign shift_s0  = accept && (!pad || pad_taken);

	assign k_s0       = (WDIM_W'(store_ptr_q) >= w_eff) ? '0 : store_ptr_q;
	assign k_ext      = WDIM_W'(k_s0);
	assign store_wrap = (k_ext + WDIM_W'(1)) >= w_eff;
	assign col_wrap   = (WDIM_W'(col_q) + WDIM_W'(1)) >= w_eff;
	assign row_wrap   = (HDIM_W'(row_q) + HDIM_W'(1)) >= h_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_ptr_q <= '0;
			fill_q      <= '0;
			col_q       <= '0;
			row_q       <= '0;
		end else if (shift_s0) begin
			store_ptr_q <= store_wrap ? '0 : k_s0 + COL_W'(1);
			if (k_ext == fill_q) begin
				fill_q <= fill_q + WDIM_W'(1);
			end
			if (!pad) begin
				col_q <= col_wrap ? '0 : col_q + COL_W'(1);
				if (col_wrap) begin
					row_q <= row_wrap ? '0 : row_q + ROW_W'(1);
				end
			end
		end
	end

	// Line stores: read at intake, written back at the same entry in the cycle after.
	always_ff @(posedge clk) begin
		if (shift_s0) begin
			up_rd_s1  <= upper_mem[k_s0];
			mid_rd_s1 <= middle_mem[k_s0];
		end
		if (v_s1) begin
			upper_mem[k_s1]  <= mid_cur;
			middle_mem[k_s1] <= '{live: !pad_s1, pix: pix_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= shift_s0;
		end
	end

	// When the write-back of the beat in stage 1 hits the entry read now, the read
	// returns stale data; the written values are forwarded instead.
	always_ff @(posedge clk) begin
		if (shift_s0) begin
			k_s1       <= k_s0;
			pix_s1     <= pad ? '0 : pix_in;
			pad_s1     <= pad;
			written_s1 <= (k_ext < fill_q);
			byp_s1     <= v_s1 && (k_s1 == k_s0);
			byp_up_s1  <= mid_cur;
			byp_mid_s1 <= '{live: !pad_s1, pix: pix_s1};
		end
	end

	// ---------------------------------------------------------------- stage 1: shift

	assign up_cur   = byp_s1 ? byp_up_s1 : up_rd_s1;
	assign mid_cur  = byp_s1 ? byp_mid_s1.pix : mid_rd_s1.pix;
	assign mid_live = byp_s1 ? byp_mid_s1.live : (written_s1 && mid_rd_s1.live);

	// The column now entering the centre carries a pixel when it was live on entry.
	assign emit      = v_s1 && win_live_q[2];
	assign ocol_last = (WDIM_W'(out_col_q) + WDIM_W'(1)) >= w_eff;
	assign orow_last = (HDIM_W'(out_row_q) + HDIM_W'(1)) >= h_eff;
	assign border    = (out_col_q == '0) || ocol_last || (out_row_q == '0) || orow_last;
	assign last      = ocol_last && orow_last;

	assign pend_inc = (pad_s1 || (pending_q == inmr_pkg::PEND_MAX)) ? pending_q
		: pending_q + PEND_W'(1);
	assign pend_upd = (win_live_q[2] && (pend_inc != '0)) ? pend_inc - PEND_W'(1) : pend_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				window_q[i] <= '0;
			end
			win_live_q <= '0;
			pending_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			ctl_s2     <= '0;
		end else begin
			ctl_s2 <= '{valid: emit, border: border, last: last};
			if (v_s1) begin
				for (int i = 0; i < 6; i++) begin
					window_q[i] <= window_q[i+3];
				end
				window_q[6] <= up_cur;
				window_q[7] <= mid_cur;
				window_q[8] <= pix_s1;
				win_live_q  <= {mid_live, win_live_q[2:1]};
				pending_q   <= pend_upd;
			end
			if (emit) begin
				out_col_q <= ocol_last ? '0 : out_col_q + COL_W'(1);
				if (ocol_last) begin
					out_row_q <= orow_last ? '0 : out_row_q + ROW_W'(1);
				end
			end
		end
	end

	// ---------------------------------------------------------------- stages 2 and 3

	// The window registers hold this beat's window for the whole cycle after the shift.
	inmr_filter u_filter (
		.clk      (clk),
		.arst_n   (arst_n),
		.window   (window_q),
		.ctl      (ctl_s2),
		.strength (strength_q),
		.push     (push),
		.result   (result)
	);

	inmr_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (result),
		.results   (filtered_stream),
		.count     (fifo_count)
	);

	// ---------------------------------------------------------------- checks

	`ASSERT_IMPLIES(credit_bound, clk, arst_n, 1'b1, used <= (CNT_W+1)'(inmr_pkg::OUT_FIFO_DEPTH), "queue plus pipeline exceeds queue depth")
	`ASSERT_IMPLIES(filter_after_shift, clk, arst_n, ctl_s2.valid, $past(v_s1) && $past(win_live_q[2]), "window entered filter without a live shift")
	`ASSERT_NEXT(ignored_pad_no_shift, clk, arst_n, accept && pad && !pad_taken, !v_s1, "ignored flush beat shifted the window")

endmodule
